@@ rtl/core/sac_pkg.sv @@
// Shared types and constants of the set-associative cache with prefetch.
`default_nettype none
package sac_pkg;
  localparam int unsigned ADDR_BITS        = 48;
  localparam int unsigned STAMP_W          = 64;
  localparam int unsigned DEF_MAX_SET_BITS = 8;
  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_MAX_PREFETCH = 8;
  localparam int unsigned CFG_AW           = 5;

  localparam logic [2:0] REG_SET_BITS   = 3'd0;
  localparam logic [2:0] REG_BLOCK_BITS = 3'd1;
  localparam logic [2:0] REG_WAYS       = 3'd2;
  localparam logic [2:0] REG_POLICY     = 3'd3;
  localparam logic [2:0] REG_PREFETCH   = 3'd4;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] address;
  } in_t;

  typedef struct packed {
    logic       plain_hit;
    logic       plain_reads;
    logic       mem_write;
    logic       pre_hit;
    logic [3:0] pre_reads;
  } out_t;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [3:0] block_bits;
    logic [3:0] ways;
    logic       policy;
    logic [3:0] prefetch_count;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_PRE,
    PH_PF
  } phase_e;

  typedef struct packed {
    logic   start;
    logic   rd;
    logic   load;
    logic   check;
    logic   lru_step;
    logic   lru_fill;
    logic   wr;
    logic   pf_next;
    logic   emit;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic pre_hit;
    logic pf_more;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/sac_ram.sv @@
// Generic single-write, registered-read RAM.
`default_nettype none
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sac_ctrl.sv @@
// Sequencer for the lookup, replacement and prefetch steps of one transaction.
`default_nettype none
module sac_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire sac_pkg::stat_t stat_i,
  output sac_pkg::cmd_t       cmd_o,
  output logic                idle_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_LOAD, S_CHK, S_LRU, S_WR, S_NEXT, S_DONE
  } state_e;

  state_e          state_q, state_d;
  sac_pkg::phase_e phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          phase_d = sac_pkg::PH_PLAIN;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.check = 1'b1;
        state_d = stat_i.need_scan ? S_LRU : S_WR;
      end
      S_LRU: begin
        if (stat_i.scan_done) begin
          cmd_o.lru_fill = 1'b1;
          state_d = S_WR;
        end else begin
          cmd_o.lru_step = 1'b1;
        end
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        case (phase_q)
          sac_pkg::PH_PLAIN: begin
            phase_d = sac_pkg::PH_PRE;
            state_d = S_RD;
          end
          sac_pkg::PH_PRE: begin
            state_d = (!stat_i.pre_hit && stat_i.pf_more) ? S_NEXT : S_DONE;
          end
          default: begin
            state_d = stat_i.pf_more ? S_NEXT : S_DONE;
          end
        endcase
      end
      S_NEXT: begin
        cmd_o.pf_next = 1'b1;
        phase_d = sac_pkg::PH_PF;
        state_d = S_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= sac_pkg::PH_PLAIN;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sac_dp.sv @@
// Datapath: tag store RAMs, working set row, access clock and result register.
`default_nettype none
module sac_dp #(
  parameter int unsigned MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = sac_pkg::DEF_MAX_WAYS,
  parameter int unsigned MAX_PREFETCH = sac_pkg::DEF_MAX_PREFETCH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sac_pkg::cfg_t  cfg_i,
  input  wire sac_pkg::in_t   in_data_i,
  input  wire sac_pkg::cmd_t  cmd_i,
  output sac_pkg::stat_t      stat_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output sac_pkg::out_t       out_data_o
);
  localparam int unsigned AB     = sac_pkg::ADDR_BITS;
  localparam int unsigned SW     = sac_pkg::STAMP_W;
  localparam int unsigned SETS   = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned PF_W   = (MAX_PREFETCH > 0) ? $clog2(MAX_PREFETCH + 1) : 1;
  localparam int unsigned EW     = 1 + AB + SW;
  localparam int unsigned RW     = MAX_WAYS * EW;

  logic              req_type_q;
  logic [AB-1:0]     cur_addr_q;
  logic [SW-1:0]     clk_q;
  logic [SET_W-1:0]  set_q;
  logic [AB-1:0]     tag_q;
  logic              wv_q [MAX_WAYS];
  logic [AB-1:0]     wt_q [MAX_WAYS];
  logic [SW-1:0]     ws_q [MAX_WAYS];
  logic [WCNT_W-1:0] scan_q;
  logic [WAY_W-1:0]  least_q;
  logic [PF_W-1:0]   pf_q;
  logic              p_hit_q, q_hit_q;
  logic [3:0]        q_reads_q;
  logic [SETS-1:0]   plain_rv_q, pre_rv_q;
  logic              out_vld_q;
  sac_pkg::out_t     out_q;

  logic [4:0]        esb;
  logic [WCNT_W-1:0] n_ways;
  logic [PF_W-1:0]   n_pf;
  logic [SET_W-1:0]  cur_set;
  logic [AB-1:0]     cur_tag, shifted;
  logic [RW-1:0]     plain_rd, pre_rd, row_rd, row_wr;
  logic              row_ok;
  logic              hit, emp;
  logic [WAY_W-1:0]  hit_idx, emp_idx, last_idx;
  logic              pre_sel;

  always_comb begin
    int unsigned wi, si, pi;
    si = 32'(cfg_i.set_bits);
    if (si > MAX_SET_BITS) si = MAX_SET_BITS;
    wi = 32'(cfg_i.ways);
    if (wi == 0) wi = 1;
    if (wi > MAX_WAYS) wi = MAX_WAYS;
    pi = 32'(cfg_i.prefetch_count);
    if (pi > MAX_PREFETCH) pi = MAX_PREFETCH;
    esb    = 5'(si);
    n_ways = WCNT_W'(wi);
    n_pf   = PF_W'(pi);
  end

  assign shifted  = cur_addr_q >> cfg_i.block_bits;
  assign cur_set  = shifted[SET_W-1:0] & SET_W'((32'd1 << esb) - 32'd1);
  assign cur_tag  = cur_addr_q >> (6'(cfg_i.block_bits) + 6'(esb));
  assign last_idx = WAY_W'(n_ways - WCNT_W'(1));
  assign pre_sel  = (cmd_i.phase != sac_pkg::PH_PLAIN);

  always_comb begin
    hit = 1'b0;
    emp = 1'b0;
    hit_idx = '0;
    emp_idx = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(n_ways)) begin
        if (!hit && wv_q[w] && wt_q[w] == tag_q) begin
          hit = 1'b1;
          hit_idx = WAY_W'(w);
        end
        if (!emp && !wv_q[w]) begin
          emp = 1'b1;
          emp_idx = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_wr[w*EW +: EW] = {wv_q[w], wt_q[w], ws_q[w]};
    end
  end

  assign row_rd = pre_sel ? pre_rd : plain_rd;
  assign row_ok = pre_sel ? pre_rv_q[set_q] : plain_rv_q[set_q];

  sac_ram #(.WIDTH(RW), .DEPTH(SETS)) u_plain_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr && !pre_sel),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.rd),
    .raddr_i (cur_set),
    .rdata_o (plain_rd)
  );

  sac_ram #(.WIDTH(RW), .DEPTH(SETS)) u_pre_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr && pre_sel),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.rd),
    .raddr_i (cur_set),
    .rdata_o (pre_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_type_q <= in_data_i.req_type;
      cur_addr_q <= in_data_i.address;
    end else if (cmd_i.pf_next) begin
      cur_addr_q <= cur_addr_q + (AB'(1) << cfg_i.block_bits);
    end
    if (cmd_i.rd) begin
      set_q <= cur_set;
      tag_q <= cur_tag;
    end
    if (cmd_i.load) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row_ok) begin
          {wv_q[w], wt_q[w], ws_q[w]} <= row_rd[w*EW +: EW];
        end else begin
          wv_q[w] <= 1'b0;
          wt_q[w] <= '0;
          ws_q[w] <= '0;
        end
      end
    end
    if (cmd_i.check) begin
      if (hit) begin
        ws_q[hit_idx] <= clk_q;
      end else if (emp) begin
        wv_q[emp_idx] <= 1'b1;
        wt_q[emp_idx] <= tag_q;
        ws_q[emp_idx] <= clk_q;
      end else if (!cfg_i.policy) begin
        for (int w = 0; w + 1 < MAX_WAYS; w++) begin
          if (w + 1 < int'(n_ways)) begin
            wv_q[w] <= wv_q[w+1];
            wt_q[w] <= wt_q[w+1];
            ws_q[w] <= ws_q[w+1];
          end
        end
        wv_q[last_idx] <= 1'b1;
        wt_q[last_idx] <= tag_q;
        ws_q[last_idx] <= clk_q;
      end else begin
        least_q <= '0;
        scan_q  <= WCNT_W'(1);
      end
    end
    if (cmd_i.lru_step) begin
      if (ws_q[scan_q[WAY_W-1:0]] < ws_q[least_q]) begin
        least_q <= scan_q[WAY_W-1:0];
      end
      scan_q <= scan_q + WCNT_W'(1);
    end
    if (cmd_i.lru_fill) begin
      wv_q[least_q] <= 1'b1;
      wt_q[least_q] <= tag_q;
      ws_q[least_q] <= clk_q;
    end
    if (cmd_i.emit) begin
      out_q.plain_hit   <= p_hit_q;
      out_q.plain_reads <= !p_hit_q;
      out_q.mem_write   <= req_type_q;
      out_q.pre_hit     <= q_hit_q;
      out_q.pre_reads   <= q_reads_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q      <= '0;
      plain_rv_q <= '0;
      pre_rv_q   <= '0;
      pf_q       <= '0;
      p_hit_q    <= 1'b0;
      q_hit_q    <= 1'b0;
      q_reads_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        clk_q     <= clk_q + SW'(1);
        pf_q      <= '0;
        q_reads_q <= '0;
      end else if (cmd_i.pf_next) begin
        clk_q <= clk_q + SW'(1);
        pf_q  <= pf_q + PF_W'(1);
      end
      if (cmd_i.check) begin
        case (cmd_i.phase)
          sac_pkg::PH_PLAIN: p_hit_q <= hit;
          sac_pkg::PH_PRE: begin
            q_hit_q   <= hit;
            q_reads_q <= hit ? 4'd0 : 4'd1;
          end
          default: begin
            if (!hit && q_reads_q != 4'd15) begin
              q_reads_q <= q_reads_q + 4'd1;
            end
          end
        endcase
      end
      if (cmd_i.wr) begin
        if (pre_sel) begin
          pre_rv_q[set_q] <= 1'b1;
        end else begin
          plain_rv_q[set_q] <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign stat_o.need_scan = !hit && !emp && cfg_i.policy;
  assign stat_o.scan_done = (scan_q >= n_ways);
  assign stat_o.pre_hit   = q_hit_q;
  assign stat_o.pf_more   = (pf_q < n_pf);
  assign stat_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

@@ rtl/core/set_assoc_cache_with_prefetch.sv @@
// Each tag lookup steps through read, load, check and write back, plus a scan over
// the ways in use under LRU eviction in a full set. A transaction is an accept, a
// plain and a prefetch lookup, probes of the next blocks on a prefetch miss, an emit;
// one transaction is in flight at a time, the result register frees the next accept.
// Reset: configuration returns to defaults and per-set valid flags clear at once;
// no clearing pass is needed.
`default_nettype none
module set_assoc_cache_with_prefetch #(
  parameter int unsigned MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = sac_pkg::DEF_MAX_WAYS,
  parameter int unsigned MAX_PREFETCH = sac_pkg::DEF_MAX_PREFETCH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire sac_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output sac_pkg::out_t                   out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sac_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  sac_pkg::cfg_t  cfg_q;
  sac_pkg::cmd_t  cmd;
  sac_pkg::stat_t stat;
  logic           idle;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits       <= 4'd0;
      cfg_q.block_bits     <= 4'd6;
      cfg_q.ways           <= 4'd8;
      cfg_q.policy         <= 1'b0;
      cfg_q.prefetch_count <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        sac_pkg::REG_SET_BITS:   cfg_q.set_bits       <= pwdata[3:0];
        sac_pkg::REG_BLOCK_BITS: cfg_q.block_bits     <= pwdata[3:0];
        sac_pkg::REG_WAYS:       cfg_q.ways           <= pwdata[3:0];
        sac_pkg::REG_POLICY:     cfg_q.policy         <= pwdata[0];
        sac_pkg::REG_PREFETCH:   cfg_q.prefetch_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sac_pkg::REG_SET_BITS:   prdata = {28'd0, cfg_q.set_bits};
      sac_pkg::REG_BLOCK_BITS: prdata = {28'd0, cfg_q.block_bits};
      sac_pkg::REG_WAYS:       prdata = {28'd0, cfg_q.ways};
      sac_pkg::REG_POLICY:     prdata = {31'd0, cfg_q.policy};
      sac_pkg::REG_PREFETCH:   prdata = {28'd0, cfg_q.prefetch_count};
      default:                 prdata = 32'd0;
    endcase
  end

  assign in_stall_o = !idle;

  sac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  sac_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .MAX_PREFETCH (MAX_PREFETCH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire
